[rtl/binary_speck_neighbour_filter_unit_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the speck neighbour filter
// Clocked property checks that can be compiled out with NO_ASSERTIONS.
// ----------------------------------------------------------------------------
`ifndef BINARY_SPECK_NEIGHBOUR_FILTER_UNIT_MACROS_SVH
`define BINARY_SPECK_NEIGHBOUR_FILTER_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Check a property outside reset
`define BSNF_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("bsnf assertion failed");

// Check a property on every edge, reset included
`define BSNF_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) (prop)) \
    else $error("bsnf assertion failed");

`else

`define BSNF_ASSERT(label, prop)
`define BSNF_ASSERT_ALWAYS(label, prop)

`endif

`endif

[rtl/bsnf_pkg.sv]
// ----------------------------------------------------------------------------
// bsnf_pkg
// Shared constants, register indexes and types of the speck neighbour filter.
// ----------------------------------------------------------------------------
package bsnf_pkg;

  // Pixel format
  localparam int PIX_W = 8;
  localparam logic [PIX_W-1:0] PIX_WHITE = 8'hFF;
  localparam logic [PIX_W-1:0] PIX_BLACK = 8'h00;

  // Configuration port
  localparam int CFG_W   = 11;
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

  // Frame size after reset
  localparam int RESET_WIDTH  = 640;
  localparam int RESET_HEIGHT = 480;

  // Default frame limits
  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 1024;

  // Result queue depth (power of two, at least 2)
  localparam int RES_FIFO_DEPTH = 4;

  // Position of the request in flight, decoded at accept
  typedef struct packed {
    logic interior;   // neighbour (row-1, col-1) gets its final write
    logic border;     // the pixel itself lies on the frame border
    logic row_start;  // first column of a row
    logic row_end;    // last column of a row
  } bsnf_pos_t;

endpackage

[rtl/bsnf_line_ram.sv]
// ----------------------------------------------------------------------------
// bsnf_line_ram
// One row of pixels: synchronous memory, one write and one read port,
// registered read data.
// ----------------------------------------------------------------------------
module bsnf_line_ram import bsnf_pkg::*; #(
  parameter int DEPTH = DEF_MAX_WIDTH,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [PIX_W-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [PIX_W-1:0]  rdata
);

  logic [PIX_W-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, data held until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/bsnf_window.sv]
// ----------------------------------------------------------------------------
// bsnf_window
// 3x3 neighbourhood around (row-1, col-1), speck decision, write-back to the
// line memories and formatting of the result words.
// ----------------------------------------------------------------------------
module bsnf_window import bsnf_pkg::*; #(
  parameter int COL_W = 10,
  parameter int ROW_W = 10,
  parameter int RES_W = ROW_W + COL_W + PIX_W + 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             fire,
  input  bsnf_pos_t        pos,
  input  logic [ROW_W-1:0] row,
  input  logic [COL_W-1:0] col,
  input  logic [PIX_W-1:0] pixel,
  input  logic [PIX_W-1:0] fin_rdata,
  input  logic [PIX_W-1:0] mid_rdata,
  output logic             fin_we,
  output logic [COL_W-1:0] fin_waddr,
  output logic [PIX_W-1:0] fin_wdata,
  output logic             mid_we,
  output logic [COL_W-1:0] mid_waddr,
  output logic [PIX_W-1:0] mid_wdata,
  output logic [1:0]       res_n,
  output logic [RES_W-1:0] res_word0,
  output logic [RES_W-1:0] res_word1
);

  // Window columns c-1 and c-2 of the three rows
  logic [PIX_W-1:0] fin_d1;
  logic [PIX_W-1:0] fin_d2;
  logic [PIX_W-1:0] mid_d1;
  logic [PIX_W-1:0] mid_left;
  logic [PIX_W-1:0] inc_d1;
  logic [PIX_W-1:0] inc_d2;

  // Last column of the finished row, written at the next row start
  logic             tail_pending;
  logic [COL_W-1:0] tail_addr;
  logic [PIX_W-1:0] tail_value;

  logic [7:0]       zero_vec;
  logic [3:0]       zeros;
  logic             do_fill;
  logic [PIX_W-1:0] center;
  logic [RES_W-1:0] inner_word;
  logic [RES_W-1:0] edge_word;

  // Count black neighbours and decide the fill
  always_comb begin
    zero_vec = {fin_d2 == PIX_BLACK, fin_d1 == PIX_BLACK, fin_rdata == PIX_BLACK,
                mid_left == PIX_BLACK, mid_rdata == PIX_BLACK,
                inc_d2 == PIX_BLACK, inc_d1 == PIX_BLACK, pixel == PIX_BLACK};
    zeros    = 4'($countones(zero_vec));
    do_fill  = pos.interior && (mid_d1 != PIX_WHITE) &&
               (zeros != 4'd0) && (zeros != 4'd8);
    center   = do_fill ? PIX_WHITE : mid_d1;
  end

  // Write back the final middle value and the incoming pixel
  always_comb begin
    fin_we    = fire && (!pos.row_start || tail_pending);
    fin_waddr = pos.row_start ? tail_addr : COL_W'(col - COL_W'(1));
    fin_wdata = pos.row_start ? tail_value : center;
    mid_we    = fire;
    mid_waddr = col;
    mid_wdata = pixel;
  end

  // Format results: interior write first, border write second
  always_comb begin
    inner_word = {ROW_W'(row - ROW_W'(1)), COL_W'(col - COL_W'(1)), center,
                  !pos.border};
    edge_word  = {row, col, pixel, 1'b1};
    res_n      = 2'd0;
    res_word0  = edge_word;
    res_word1  = edge_word;
    if (fire) begin
      res_n = 2'({1'b0, pos.interior} + {1'b0, pos.border});
      if (pos.interior) begin
        res_word0 = inner_word;
      end
    end
  end

  // Advance the window
  always_ff @(posedge clk) begin
    if (fire) begin
      fin_d2   <= fin_d1;
      fin_d1   <= fin_rdata;
      mid_d1   <= mid_rdata;
      mid_left <= center;
      inc_d2   <= inc_d1;
      inc_d1   <= pixel;
      if (pos.row_end) begin
        tail_addr  <= col;
        tail_value <= mid_rdata;
      end
    end
  end

  // Track the deferred last-column write
  always_ff @(posedge clk) begin
    if (rst) begin
      tail_pending <= 1'b0;
    end else if (fire) begin
      if (pos.row_end) begin
        tail_pending <= 1'b1;
      end else if (pos.row_start) begin
        tail_pending <= 1'b0;
      end
    end
  end

endmodule

[rtl/bsnf_result_fifo.sv]
// ----------------------------------------------------------------------------
// bsnf_result_fifo
// Small result queue: takes up to two words a cycle, gives one.
// ----------------------------------------------------------------------------
module bsnf_result_fifo import bsnf_pkg::*; #(
  parameter int WORD_W = 29,
  parameter int DEPTH  = RES_FIFO_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [1:0]        push_n,
  input  logic [WORD_W-1:0] push_word0,
  input  logic [WORD_W-1:0] push_word1,
  output logic              room,
  output logic              pop_valid,
  input  logic              pop_ready,
  output logic [WORD_W-1:0] pop_word
);

  `include "binary_speck_neighbour_filter_unit_macros.svh"

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WORD_W-1:0] mem [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  count_next;
  logic              pop;

  // Room for a full request of two words
  always_comb begin
    room       = count <= CNT_W'(DEPTH - 2);
    pop_valid  = count != '0;
    pop_word   = mem[rd_ptr];
    pop        = pop_valid && pop_ready;
    count_next = count + CNT_W'(push_n) - CNT_W'(pop);
  end

  // Store pushed words
  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      mem[wr_ptr] <= push_word0;
    end
    if (push_n == 2'd2) begin
      mem[PTR_W'(wr_ptr + PTR_W'(1))] <= push_word1;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= PTR_W'(wr_ptr + PTR_W'(push_n));
      rd_ptr <= PTR_W'(rd_ptr + PTR_W'(pop));
      count  <= count_next;
    end
  end

  `BSNF_ASSERT(a_fifo_bound, count <= CNT_W'(DEPTH))
  `BSNF_ASSERT(a_push_has_room, (push_n != 2'd0) |-> room)
  `BSNF_ASSERT(a_push_code, push_n != 2'd3)

endmodule

[rtl/binary_speck_neighbour_filter_unit.sv]
// ----------------------------------------------------------------------------
// binary_speck_neighbour_filter_unit
// Pixels enter on in_valid/in_ready in raster order, one request each; every
// pixel's final value leaves once as an addressed write on out_valid/out_ready
// (write_row, write_column, final_value, last_of_item). Interior pixels are
// written when the pixel below-right arrives; border pixels on arrival.
// Throughput: one pixel per clock. Each pixel reads its column of the two
// line memories (finished row, middle row) once and writes each once, so the
// single read and write port of each memory sets that rate. A pixel gives 0,
// 1 or 2 writes; rows give one write per pixel on average, the last row of a
// frame nearly two, and output bandwidth of one write per clock sets the rate
// there. Each write passes the request register and then the result queue.
// When out_ready is low, writes collect in a four-entry queue; input stalls
// once it cannot hold two more. Reset sets 640x480 and row 0, column 0; the
// line memories need no clearing. A write to frame_width or frame_height
// restarts the frame at row 0, column 0; sizes clamp to 1..MAX.
// ----------------------------------------------------------------------------
module binary_speck_neighbour_filter_unit import bsnf_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
  parameter int COL_W = $clog2(MAX_WIDTH),
  parameter int ROW_W = $clog2(MAX_HEIGHT)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [PIX_W-1:0]     pixel_value,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [ROW_W-1:0]     write_row,
  output logic [COL_W-1:0]     write_column,
  output logic [PIX_W-1:0]     final_value,
  output logic                 last_of_item
);

  `include "binary_speck_neighbour_filter_unit_macros.svh"

  localparam int RES_W = ROW_W + COL_W + PIX_W + 1;
  localparam int SZW_W = (CFG_W > COL_W + 1) ? CFG_W : COL_W + 1;
  localparam int SZH_W = (CFG_W > ROW_W + 1) ? CFG_W : ROW_W + 1;
  localparam int RESET_W_EFF = (RESET_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RESET_WIDTH;
  localparam int RESET_H_EFF = (RESET_HEIGHT > MAX_HEIGHT) ? MAX_HEIGHT : RESET_HEIGHT;

  // Frame size, kept as the last column and last row index
  logic [COL_W-1:0] width_last;
  logic [COL_W-1:0] width_last_next;
  logic [ROW_W-1:0] height_last;
  logic [ROW_W-1:0] height_last_next;
  logic [SZW_W-1:0] cfg_w_ext;
  logic [SZH_W-1:0] cfg_h_ext;
  logic             cfg_hit;

  // Raster position of the next pixel
  logic [COL_W-1:0] col_cnt;
  logic [ROW_W-1:0] row_cnt;

  // Request in flight, waiting for its memory reads
  logic             s1_valid;
  bsnf_pos_t        s1_pos;
  logic [COL_W-1:0] s1_col;
  logic [ROW_W-1:0] s1_row;
  logic [PIX_W-1:0] s1_pixel;
  bsnf_pos_t        pos_in;

  logic             accept;
  logic             fire;
  logic             room;

  logic             fin_we;
  logic [COL_W-1:0] fin_waddr;
  logic [PIX_W-1:0] fin_wdata;
  logic [PIX_W-1:0] fin_rdata;
  logic             mid_we;
  logic [COL_W-1:0] mid_waddr;
  logic [PIX_W-1:0] mid_wdata;
  logic [PIX_W-1:0] mid_rdata;

  logic [1:0]       res_n;
  logic [RES_W-1:0] res_word0;
  logic [RES_W-1:0] res_word1;
  logic [RES_W-1:0] head_word;

  // Clamp written sizes into 1..MAX
  always_comb begin
    cfg_w_ext = SZW_W'(cfg_data);
    cfg_h_ext = SZH_W'(cfg_data);
    if (cfg_w_ext == '0) begin
      width_last_next = '0;
    end else if (cfg_w_ext > SZW_W'(MAX_WIDTH)) begin
      width_last_next = COL_W'(MAX_WIDTH - 1);
    end else begin
      width_last_next = COL_W'(cfg_w_ext - SZW_W'(1));
    end
    if (cfg_h_ext == '0) begin
      height_last_next = '0;
    end else if (cfg_h_ext > SZH_W'(MAX_HEIGHT)) begin
      height_last_next = ROW_W'(MAX_HEIGHT - 1);
    end else begin
      height_last_next = ROW_W'(cfg_h_ext - SZH_W'(1));
    end
    cfg_hit = cfg_write &&
              ((cfg_index == REG_FRAME_WIDTH) || (cfg_index == REG_FRAME_HEIGHT));
  end

  // Hold the frame size
  always_ff @(posedge clk) begin
    if (rst) begin
      width_last  <= COL_W'(RESET_W_EFF - 1);
      height_last <= ROW_W'(RESET_H_EFF - 1);
    end else if (cfg_write) begin
      if (cfg_index == REG_FRAME_WIDTH) begin
        width_last <= width_last_next;
      end
      if (cfg_index == REG_FRAME_HEIGHT) begin
        height_last <= height_last_next;
      end
    end
  end

  // Handshake and position decode
  always_comb begin
    fire             = s1_valid && room;
    in_ready         = !s1_valid || fire;
    accept           = in_valid && in_ready;
    pos_in.interior  = (row_cnt >= ROW_W'(2)) && (col_cnt >= COL_W'(2));
    pos_in.border    = (row_cnt == '0) || (row_cnt == height_last) ||
                       (col_cnt == '0) || (col_cnt == width_last);
    pos_in.row_start = col_cnt == '0;
    pos_in.row_end   = col_cnt == width_last;
  end

  // Advance the raster position; restart on a size write
  always_ff @(posedge clk) begin
    if (rst || cfg_hit) begin
      col_cnt <= '0;
      row_cnt <= '0;
    end else if (accept) begin
      if (col_cnt == width_last) begin
        col_cnt <= '0;
        row_cnt <= (row_cnt == height_last) ? '0 : ROW_W'(row_cnt + ROW_W'(1));
      end else begin
        col_cnt <= COL_W'(col_cnt + COL_W'(1));
      end
    end
  end

  // Hold the request while its reads complete
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pos   <= pos_in;
      s1_col   <= col_cnt;
      s1_row   <= row_cnt;
      s1_pixel <= pixel_value;
    end
  end

  // Finished row: fully filtered row r-2
  bsnf_line_ram #(
    .DEPTH  (MAX_WIDTH),
    .ADDR_W (COL_W)
  ) u_fin_ram (
    .clk   (clk),
    .we    (fin_we),
    .waddr (fin_waddr),
    .wdata (fin_wdata),
    .re    (accept),
    .raddr (col_cnt),
    .rdata (fin_rdata)
  );

  // Middle row: original row r-1 ahead of the column, row r behind it
  bsnf_line_ram #(
    .DEPTH  (MAX_WIDTH),
    .ADDR_W (COL_W)
  ) u_mid_ram (
    .clk   (clk),
    .we    (mid_we),
    .waddr (mid_waddr),
    .wdata (mid_wdata),
    .re    (accept),
    .raddr (col_cnt),
    .rdata (mid_rdata)
  );

  bsnf_window #(
    .COL_W (COL_W),
    .ROW_W (ROW_W),
    .RES_W (RES_W)
  ) u_window (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .pos       (s1_pos),
    .row       (s1_row),
    .col       (s1_col),
    .pixel     (s1_pixel),
    .fin_rdata (fin_rdata),
    .mid_rdata (mid_rdata),
    .fin_we    (fin_we),
    .fin_waddr (fin_waddr),
    .fin_wdata (fin_wdata),
    .mid_we    (mid_we),
    .mid_waddr (mid_waddr),
    .mid_wdata (mid_wdata),
    .res_n     (res_n),
    .res_word0 (res_word0),
    .res_word1 (res_word1)
  );

  bsnf_result_fifo #(
    .WORD_W (RES_W),
    .DEPTH  (RES_FIFO_DEPTH)
  ) u_result_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_n     (res_n),
    .push_word0 (res_word0),
    .push_word1 (res_word1),
    .room       (room),
    .pop_valid  (out_valid),
    .pop_ready  (out_ready),
    .pop_word   (head_word)
  );

  // Unpack the head result
  assign {write_row, write_column, final_value, last_of_item} = head_word;

  `BSNF_ASSERT(a_col_in_frame, col_cnt <= width_last)
  `BSNF_ASSERT(a_row_in_frame, row_cnt <= height_last)
  `BSNF_ASSERT(a_cfg_restart, cfg_hit |=> (col_cnt == '0) && (row_cnt == '0))

endmodule
